[rtl/lca_pkg.sv]
// ----------------------------------------------------------------------------
// lca_pkg
// shared sizes, codes and memory request type for the life grid step block
// ----------------------------------------------------------------------------
package lca_pkg;

    localparam int GRID_SIDE = 64;
    localparam int ROW_W     = $clog2(GRID_SIDE);
    localparam int COORD_W   = 6;

    // on-grid compare against the side length, one bit wider than a coordinate
    localparam logic [COORD_W:0] SIDE_CMP = (COORD_W + 1)'(GRID_SIDE);

    // neighbor counts of the b3/s23 rule
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_STEP  = 2'd2
    } kind_t;

    typedef struct packed {
        logic                  rd_en;
        logic [ROW_W-1:0]      rd_addr;
        logic                  wr_en;
        logic [ROW_W-1:0]      wr_addr;
        logic [GRID_SIDE-1:0]  wr_data;
    } grid_req_t;

endpackage

[rtl/lca_rule_row.sv]
// ----------------------------------------------------------------------------
// lca_rule_row
// row-wide b3/s23 rule unit: next state of one row from the rows around it
// ----------------------------------------------------------------------------
module lca_rule_row (
    input  logic [lca_pkg::GRID_SIDE-1:0] row_up,
    input  logic [lca_pkg::GRID_SIDE-1:0] row_mid,
    input  logic [lca_pkg::GRID_SIDE-1:0] row_down,
    output logic [lca_pkg::GRID_SIDE-1:0] row_next
);
    import lca_pkg::*;

    // zero padding on both edges, column c sits at padded bit c+1
    logic [GRID_SIDE+1:0] up_pad;
    logic [GRID_SIDE+1:0] mid_pad;
    logic [GRID_SIDE+1:0] down_pad;

    assign up_pad   = {1'b0, row_up, 1'b0};
    assign mid_pad  = {1'b0, row_mid, 1'b0};
    assign down_pad = {1'b0, row_down, 1'b0};

    for (genvar c = 0; c < GRID_SIDE; c++) begin : g_col
        logic [3:0] cnt;

        assign cnt = 4'(up_pad[c])   + 4'(up_pad[c+1])   + 4'(up_pad[c+2])
                   + 4'(mid_pad[c])                      + 4'(mid_pad[c+2])
                   + 4'(down_pad[c]) + 4'(down_pad[c+1]) + 4'(down_pad[c+2]);

        assign row_next[c] = (cnt == BIRTH_COUNT) || (row_mid[c] && (cnt == SURVIVE_COUNT));
    end

endmodule

[rtl/lca_grid_mem.sv]
// ----------------------------------------------------------------------------
// lca_grid_mem
// grid row store, one write and one registered read per cycle, with per-row
// valid bits so that rows never written read as dead
// ----------------------------------------------------------------------------
module lca_grid_mem (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lca_pkg::grid_req_t            req,
    output logic [lca_pkg::GRID_SIDE-1:0] rd_row
);
    import lca_pkg::*;

    logic [GRID_SIDE-1:0] grid_mem_reg [GRID_SIDE];
    logic [GRID_SIDE-1:0] row_vld_reg;
    logic [GRID_SIDE-1:0] rd_data_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            grid_mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= grid_mem_reg[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (req.wr_en) begin
                row_vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_vld_reg <= row_vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_row = rd_vld_reg ? rd_data_reg : '0;

endmodule

[rtl/life_cellular_automaton_step.sv]
// ----------------------------------------------------------------------------
// life_cellular_automaton_step
// 64 x 64 game of life grid with cell write, cell read and generation step
// ----------------------------------------------------------------------------
// channel  dir  tdata                                  tuser
// s_       in   row[5:0] col[11:6] value[12]           kind[1:0]
// m_       out  alive[0]                               -
//
// cell write or read: the word passes the read and use states, then the done state loads the result
// generation step: rows are swept one at a time through the single
//   read port of the grid store and the shared row rule unit
// s_tready is high only while the sequencer is idle
// a finished result waits in the output register; the next word is taken
//   meanwhile and is held at its end until the output register frees up
// reset clears the grid to dead through per-row valid bits, no sweep needed
// ----------------------------------------------------------------------------
module life_cellular_automaton_step (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // row[5:0], col[11:6], value[12]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // alive[0]
);
    import lca_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD_RD,
        ST_CMD_USE,
        ST_FILL,
        ST_PRIME,
        ST_SWEEP,
        ST_DONE
    } state_t;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_SIDE - 1);
    localparam logic [ROW_W-1:0] PRE_LAST = ROW_W'(GRID_SIDE - 2);

    state_t               state_reg;
    logic [1:0]           kind_reg;
    logic [COORD_W-1:0]   row_reg;
    logic [COORD_W-1:0]   col_reg;
    logic                 value_reg;
    logic                 on_grid_reg;
    logic [ROW_W-1:0]     row_cnt_reg;
    logic [GRID_SIDE-1:0] above_reg;
    logic [GRID_SIDE-1:0] here_reg;
    logic                 res_alive_reg;
    logic                 m_tvalid_reg;
    logic                 m_alive_reg;

    grid_req_t            mem_req;
    logic [GRID_SIDE-1:0] rd_row;
    logic [GRID_SIDE-1:0] below_row;
    logic [GRID_SIDE-1:0] rule_row;
    logic [GRID_SIDE-1:0] cell_row;
    logic [ROW_W-1:0]     col_idx;
    logic                 s_on_grid;
    logic                 out_free;

    lca_grid_mem u_grid_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_row  (rd_row)
    );

    lca_rule_row u_rule_row (
        .row_up   (above_reg),
        .row_mid  (here_reg),
        .row_down (below_row),
        .row_next (rule_row)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'd0, m_alive_reg};
    assign out_free  = !m_tvalid_reg || m_tready;
    assign col_idx   = col_reg[ROW_W-1:0];
    assign below_row = (row_cnt_reg == LAST_ROW) ? '0 : rd_row;
    assign s_on_grid = ({1'b0, s_tdata[5:0]} < SIDE_CMP) && ({1'b0, s_tdata[11:6]} < SIDE_CMP);

    // single cell update of the row just read
    always_comb begin
        cell_row          = rd_row;
        cell_row[col_idx] = value_reg;
    end

    // grid store requests
    always_comb begin
        mem_req         = '0;
        mem_req.rd_addr = row_reg[ROW_W-1:0];
        mem_req.wr_addr = row_reg[ROW_W-1:0];
        mem_req.wr_data = cell_row;
        unique case (state_reg)
            ST_CMD_RD: begin
                mem_req.rd_en = on_grid_reg;
            end
            ST_CMD_USE: begin
                mem_req.wr_en = on_grid_reg && (kind_reg == KIND_WRITE);
            end
            ST_FILL: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
            end
            ST_PRIME: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ROW_W'(1);
            end
            ST_SWEEP: begin
                mem_req.rd_en   = (row_cnt_reg < PRE_LAST);
                mem_req.rd_addr = row_cnt_reg + ROW_W'(2);
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = row_cnt_reg;
                mem_req.wr_data = rule_row;
            end
            default: begin
                mem_req.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg    <= s_tuser;
                        row_reg     <= s_tdata[5:0];
                        col_reg     <= s_tdata[11:6];
                        value_reg   <= s_tdata[12];
                        on_grid_reg <= s_on_grid;
                        state_reg   <= (s_tuser == KIND_STEP) ? ST_FILL : ST_CMD_RD;
                    end
                end
                ST_CMD_RD: begin
                    state_reg <= ST_CMD_USE;
                end
                ST_CMD_USE: begin
                    res_alive_reg <= on_grid_reg && (kind_reg == KIND_READ) && rd_row[col_idx];
                    state_reg     <= ST_DONE;
                end
                ST_FILL: begin
                    state_reg <= ST_PRIME;
                end
                ST_PRIME: begin
                    above_reg   <= '0;
                    here_reg    <= rd_row;
                    row_cnt_reg <= '0;
                    state_reg   <= ST_SWEEP;
                end
                ST_SWEEP: begin
                    above_reg   <= here_reg;
                    here_reg    <= below_row;
                    row_cnt_reg <= row_cnt_reg + 1'b1;
                    if (row_cnt_reg == LAST_ROW) begin
                        res_alive_reg <= 1'b0;
                        state_reg     <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_alive_reg  <= res_alive_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // grid is written only while applying a cell write or sweeping rows
    a_wr_only_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> (state_reg == ST_CMD_USE || state_reg == ST_SWEEP))
        else $error("grid write outside update states");

    // an accepted word always starts work
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start work");

    // sweep advances one row per cycle
    a_sweep_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && $past(state_reg) == ST_SWEEP)
            |-> (row_cnt_reg == ROW_W'($past(row_cnt_reg) + 1'b1)))
        else $error("sweep row counter skipped");

    // a new result only comes out of the completion state
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid_reg || m_tready) ##1 m_tvalid_reg |-> ($past(state_reg) == ST_DONE))
        else $error("result word without completion");

endmodule
